>>> sv/mtc_pkg.sv
`default_nettype none

package mtc_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam int BOT_W     = 14;
	localparam int TOP_W     = 16;
	localparam int STAMP_W   = 31;
	localparam int SLOT_W    = 6;
	localparam int ORIENT_W  = 2;
	localparam int ORIENT_LSB = 14;
	localparam int CFG_W     = 7;
	localparam int COUNT_W   = 32;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_FLUSH  = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	// search state carried from cell to cell
	typedef struct packed {
		logic               busy;
		logic               found;
		idx_t               pick;
		logic               have_free;
		idx_t               free_idx;
		logic               have_old;
		logic [STAMP_W-1:0] oldest;
		idx_t               old_idx;
	} scan_pkt_t;

	// broadcast update of one entry
	typedef struct packed {
		logic en;
		logic miss;
		idx_t idx;
	} wr_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

endpackage

`default_nettype wire

>>> sv/mtc_cell.sv
`default_nettype none

module mtc_cell (
	input  wire                         clk,
	input  wire                         arst_n,
	input  mtc_pkg::idx_t               cell_idx,
	input  wire  [mtc_pkg::CNT_W-1:0]   active_n,
	input  wire  [mtc_pkg::BOT_W-1:0]   bot_key,
	input  wire  [mtc_pkg::TOP_W-1:0]   top_key,
	input  wire  [mtc_pkg::STAMP_W-1:0] frame,
	input  wire                         flush,
	input  mtc_pkg::wr_cmd_t            wr,
	input  mtc_pkg::scan_pkt_t          pkt_in,
	output mtc_pkg::scan_pkt_t          pkt_out
);
	import mtc_pkg::*;

	logic               valid_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [TOP_W-1:0]   top_q;
	logic [BOT_W-1:0]   bot_q;
	scan_pkt_t          pkt_q;
	scan_pkt_t          pkt_d;
	logic               in_use;
	logic               sel;

	assign in_use  = ({1'b0, cell_idx} < {1'b0, active_n});
	assign sel     = wr.en && (wr.idx == cell_idx);
	assign pkt_out = pkt_q;

	always_comb begin
		pkt_d = pkt_in;
		// inactive cells and cells past a hit leave the word untouched
		if (pkt_in.busy && in_use && !pkt_in.found) begin
			if (valid_q) begin
				if (top_q == top_key && bot_q == bot_key) begin
					pkt_d.found = 1'b1;
					pkt_d.pick  = cell_idx;
				end else if (!pkt_in.have_old || stamp_q < pkt_in.oldest) begin
					pkt_d.have_old = 1'b1;
					pkt_d.oldest   = stamp_q;
					pkt_d.old_idx  = cell_idx;
				end
			end else if (!pkt_in.have_free) begin
				pkt_d.have_free = 1'b1;
				pkt_d.free_idx  = cell_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			pkt_q      <= '0;
		end else begin
			pkt_q <= pkt_d;
			if (flush) begin
				valid_q <= 1'b0;
			end else if (sel && wr.miss) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			stamp_q <= frame;
			if (wr.miss) begin
				top_q <= top_key;
				bot_q <= bot_key;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/merged_texture_cache_lru_top.sv
`default_nettype none

// Channel  Direction  Handshake            Word
// in       to block   in_valid / in_stall  action, bottom_texture, top_tile_word, frame_number
// out      from block out_valid / out_stall hit, slot, orientation, hit_count, miss_count
// cfg      to block   cfg_valid / cfg_ready cfg_data (active_entries)
//
// A lookup loads the key, passes the search word through every cell register of the chain,
// captures the result, then commits it. Cost is set by chain length, not by active_entries.
// A flush gives no word.
// Reset clears valid marks, counters and control; entry payload is not reset.
// A finished lookup waits in commit while out is stalled; in is stalled until commit.

module merged_texture_cache_lru_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            action,
	input  wire  [mtc_pkg::BOT_W-1:0]      bottom_texture,
	input  wire  [mtc_pkg::TOP_W-1:0]      top_tile_word,
	input  wire  [mtc_pkg::STAMP_W-1:0]    frame_number,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic                           hit,
	output logic [mtc_pkg::SLOT_W-1:0]     slot,
	output logic [mtc_pkg::ORIENT_W-1:0]   orientation,
	output logic [mtc_pkg::COUNT_W-1:0]    hit_count,
	output logic [mtc_pkg::COUNT_W-1:0]    miss_count,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [mtc_pkg::CFG_W-1:0]      cfg_data
);
	import mtc_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   active_q;
	logic [BOT_W-1:0]   bot_q;
	logic [TOP_W-1:0]   top_q;
	logic [STAMP_W-1:0] frame_q;
	logic               start_q;
	scan_pkt_t          res_q;
	logic               out_valid_q;
	logic               hit_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [ORIENT_W-1:0] orient_q;
	logic [COUNT_W-1:0] hits_q;
	logic [COUNT_W-1:0] misses_q;

	logic               in_acc;
	logic               flush;
	logic               out_free;
	logic               commit;
	idx_t               pick_c;
	wr_cmd_t            wr;
	scan_pkt_t          chain [MAX_ENTRIES+1];
	logic [MAX_ENTRIES:0] busy_v;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign flush     = in_acc && (action == ACT_FLUSH);
	assign out_free  = !out_valid_q || !out_stall;
	assign commit    = (state_q == ST_COMMIT) && out_free;

	always_comb begin
		if (res_q.found) begin
			pick_c = res_q.pick;
		end else if (res_q.have_free) begin
			pick_c = res_q.free_idx;
		end else begin
			pick_c = res_q.old_idx;
		end
	end

	assign wr.en   = commit;
	assign wr.miss = !res_q.found;
	assign wr.idx  = pick_c;

	always_comb begin
		chain[0]      = '0;
		chain[0].busy = start_q;
	end

	for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
		mtc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(k)),
			.active_n (active_q),
			.bot_key  (bot_q),
			.top_key  (top_q),
			.frame    (frame_q),
			.flush    (flush),
			.wr       (wr),
			.pkt_in   (chain[k]),
			.pkt_out  (chain[k+1])
		);
	end

	for (genvar k = 0; k <= MAX_ENTRIES; k++) begin : g_busy
		assign busy_v[k] = chain[k].busy;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && action == ACT_LOOKUP) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (chain[MAX_ENTRIES].busy) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= CNT_W'(MAX_ENTRIES);
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			hits_q      <= '0;
			misses_q    <= '0;
		end else begin
			state_q <= state_d;
			start_q <= in_acc && (action == ACT_LOOKUP);
			if (cfg_valid && cfg_ready) begin
				if (cfg_data == '0) begin
					active_q <= CNT_W'(1);
				end else if (int'(cfg_data) > MAX_ENTRIES) begin
					active_q <= CNT_W'(MAX_ENTRIES);
				end else begin
					active_q <= CNT_W'(cfg_data);
				end
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				if (res_q.found) begin
					hits_q <= hits_q + 1'b1;
				end else begin
					misses_q <= misses_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && action == ACT_LOOKUP) begin
			bot_q   <= bottom_texture;
			top_q   <= top_tile_word;
			frame_q <= frame_number;
		end
		if (state_q == ST_SCAN && chain[MAX_ENTRIES].busy) begin
			res_q <= chain[MAX_ENTRIES];
		end
		if (commit) begin
			hit_q    <= res_q.found;
			slot_q   <= SLOT_W'(pick_c);
			orient_q <= top_q[ORIENT_LSB +: ORIENT_W];
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign slot        = slot_q;
	assign orientation = orient_q;
	assign hit_count   = hits_q;
	assign miss_count  = misses_q;

	// only one search word in flight
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(busy_v))
		else $error("more than one search word in the chain");

	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain[MAX_ENTRIES].busy |-> state_q == ST_SCAN)
		else $error("search word left the chain outside scan");

	a_victim: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMMIT |-> (res_q.found || res_q.have_free || res_q.have_old))
		else $error("commit without hit, free entry or victim");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (hits_q != $past(hits_q)) != (misses_q != $past(misses_q)))
		else $error("commit must step exactly one counter");

endmodule

`default_nettype wire
